/* sv/plc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;

    localparam int X_W    = 16;
    localparam int Y_W    = 16;
    localparam int AREA_W = 48;
    localparam int MOM_W  = 64;
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_CNT_W = $clog2(MOM_W);

    localparam logic [15:0] WEIGHT_RST = 16'd19195;
    localparam logic [15:0] TOL_RST    = 16'd7;
    localparam logic [63:0] TRI_HALF   = 64'd32768;
    localparam logic [15:0] CX_MAX     = 16'h7FFF;
    localparam logic [15:0] CX_MIN     = 16'h8000;

    // configuration register indexes
    localparam logic CFG_WEIGHT = 1'b0;
    localparam logic CFG_TOL    = 1'b1;

    typedef logic signed [X_W-1:0] t_x;
    typedef logic [Y_W-1:0]        t_y;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A2,
        S_XA,
        S_SQ,
        S_SQY,
        S_HW,
        S_T1,
        S_T2L,
        S_T2H,
        S_TRA,
        S_TRB,
        S_FIN,
        S_DIV,
        S_RND
    } t_state;

    typedef struct packed {
        logic              start;
        logic [MOM_W-1:0]  num;
        logic [AREA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             rnd;
        logic [MOM_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

/* sv/plc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface plc_in_if import plc_pkg::*; ();
    logic valid;
    logic ready;
    t_x   point_x;
    t_y   point_y;
    logic last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface
`default_nettype wire

/* sv/plc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface plc_out_if import plc_pkg::*; ();
    logic valid;
    logic ready;
    t_x   centroid_x;
    logic empty_area;

    modport source (output valid, output centroid_x, output empty_area, input ready);
    modport sink (input valid, input centroid_x, input empty_area, output ready);
endinterface
`default_nettype wire

/* sv/plc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module plc_mul import plc_pkg::*; (
    input  wire                        i_clk,
    input  wire logic signed [MUL_A_W-1:0] i_a,
    input  wire logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0]      o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

/* sv/plc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module plc_div import plc_pkg::*; (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire t_div_req  i_req,
    output t_div_rsp       o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MOM_W-1:0]     r_quo;
    logic [AREA_W-1:0]    r_rem;
    logic [AREA_W-1:0]    r_den;

    logic [AREA_W:0]   w_part;
    logic [AREA_W+1:0] w_diff;

    assign w_part = {r_rem, r_quo[MOM_W-1]};
    assign w_diff = {1'b0, w_part} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one restoring step per cycle: the dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            if (!w_diff[AREA_W+1]) begin
                r_rem <= w_diff[AREA_W-1:0];
                r_quo <= {r_quo[MOM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_part[AREA_W-1:0];
                r_quo <= {r_quo[MOM_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    // round half up on the magnitude
    assign o_rsp.rnd  = ({r_rem, 1'b0} >= {1'b0, r_den});

endmodule
`default_nettype wire

/* sv/piecewise_linear_centroid_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Takes one corner point per request; ready is high only while the sequencer is idle.
// A point with no previous corner goes straight to finish; a segment uses the shared
// 35x18 multiplier for area, moment and height, a sloped one also for the triangle. The
// last point adds 64 radix-2 divider steps, a done and a rounding step (a zero area only
// rounds). The result then waits in the output register while the next curve starts.
// Synchronous active-low reset clears sums, previous corner and output; loads defaults.
module piecewise_linear_centroid_unit import plc_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire [15:0]   i_cfg_data,
    plc_in_if.sink       i_pt,
    plc_out_if.source    o_res
);

    t_state r_state, n_state;

    logic [15:0]       r_weight;
    logic [15:0]       r_tol;
    logic [X_W-1:0]    r_px;
    logic [Y_W-1:0]    r_py;
    logic              r_have;
    logic [X_W-1:0]    r_x1;
    logic [Y_W-1:0]    r_y1;
    logic              r_last;
    logic [AREA_W-1:0] r_area;
    logic [MOM_W-1:0]  r_mom;
    logic [48:0]       r_t;
    logic [63:0]       r_p;
    logic              r_neg;
    logic              r_empty;
    logic              r_ovalid;
    logic [15:0]       r_cx;
    logic              r_oempty;

    logic                      w_accept;
    logic                      w_ready;
    logic                      w_out_free;
    logic signed [16:0]        w_dx;
    logic [16:0]               w_adx_f;
    logic [15:0]               w_adx;
    logic                      w_fall;
    logic                      w_rise;
    logic                      w_flat;
    logic [15:0]               w_h;
    logic [16:0]               w_w;
    logic [15:0]               w_ylow;
    logic [16:0]               w_s;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic [MOM_W-1:0]          w_prod_ext;
    logic [AREA_W-1:0]         w_amag;
    logic [MOM_W-1:0]          w_mmag;
    logic [16:0]               w_qsat;
    logic [17:0]               w_qr;
    logic [15:0]               w_res;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;

    assign w_accept   = i_pt.valid && w_ready;
    assign w_out_free = !r_ovalid || o_res.ready;

    // segment geometry from the previous and the current corner
    assign w_dx    = {r_x1[X_W-1], r_x1} - {r_px[X_W-1], r_px};
    assign w_adx_f = w_dx[16] ? (17'd0 - w_dx) : w_dx;
    assign w_adx   = w_adx_f[15:0];
    assign w_fall  = {1'b0, r_py} > ({1'b0, r_y1} + {1'b0, r_tol});
    assign w_rise  = ({1'b0, r_py} + {1'b0, r_tol}) < {1'b0, r_y1};
    assign w_flat  = !w_fall && !w_rise;
    assign w_h     = w_fall ? (r_py - r_y1) : (w_rise ? (r_y1 - r_py) : 16'd0);
    assign w_w     = w_fall ? {1'b0, r_weight}
                   : (w_rise ? (17'h10000 - {1'b0, r_weight}) : 17'd0);
    assign w_ylow  = w_fall ? r_y1 : r_py;
    assign w_s     = w_flat ? {r_py, 1'b0} : ({1'b0, r_py} + {1'b0, r_y1});

    assign w_prod_ext = {{(MOM_W-MUL_P_W){w_prod[MUL_P_W-1]}}, w_prod};

    plc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_amag = r_area[AREA_W-1] ? (AREA_W'(0) - r_area) : r_area;
    assign w_mmag = r_mom[MOM_W-1] ? (MOM_W'(0) - r_mom) : r_mom;

    assign w_div_req.start = (r_state == S_FIN) && r_last && (r_area != '0);
    assign w_div_req.num   = w_mmag;
    assign w_div_req.den   = w_amag;

    plc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // rounding and saturation of the quotient
    assign w_qsat = (|w_div_rsp.quo[MOM_W-1:17]) ? 17'h1FFFF : w_div_rsp.quo[16:0];
    assign w_qr   = {1'b0, w_qsat} + {17'd0, w_div_rsp.rnd};
    always_comb begin
        if (r_empty) begin
            w_res = 16'd0;
        end else if (r_neg) begin
            w_res = (w_qr > {2'b00, CX_MIN}) ? CX_MIN : (16'd0 - w_qr[15:0]);
        end else begin
            w_res = (w_qr > {2'b00, CX_MAX}) ? CX_MAX : w_qr[15:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = r_have ? S_A2 : S_FIN;
            end
            S_A2:  n_state = S_XA;
            S_XA:  n_state = S_SQ;
            S_SQ:  n_state = S_SQY;
            S_SQY: n_state = S_HW;
            S_HW:  n_state = w_flat ? S_FIN : S_T1;
            S_T1:  n_state = S_T2L;
            S_T2L: n_state = S_T2H;
            S_T2H: n_state = S_TRA;
            S_TRA: n_state = S_TRB;
            S_TRB: n_state = S_FIN;
            S_FIN: begin
                if (!r_last)              n_state = S_IDLE;
                else if (r_area == '0)    n_state = S_RND;
                else                      n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) n_state = S_RND;
            end
            S_RND: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: handshake and multiplier operands
    always_comb begin
        w_ready = (r_state == S_IDLE);
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_A2: begin
                w_mul_a = {{(MUL_A_W-17){w_dx[16]}}, w_dx};
                w_mul_b = {1'b0, w_s};
            end
            S_XA: begin
                w_mul_a = w_prod[MUL_A_W-1:0];
                w_mul_b = {{(MUL_B_W-X_W){r_px[X_W-1]}}, r_px};
            end
            S_SQ: begin
                w_mul_a = {19'd0, w_adx};
                w_mul_b = {2'b00, w_adx};
            end
            S_SQY: begin
                w_mul_a = w_prod[MUL_A_W-1:0];
                w_mul_b = {2'b00, w_ylow};
            end
            S_HW: begin
                w_mul_a = {18'd0, w_w};
                w_mul_b = {2'b00, w_h};
            end
            S_T1: begin
                w_mul_a = {2'b00, w_prod[32:0]};
                w_mul_b = {2'b00, w_adx};
            end
            S_T2L: begin
                w_mul_a = {11'd0, w_prod[23:0]};
                w_mul_b = {2'b00, w_adx};
            end
            S_T2H: begin
                w_mul_a = {10'd0, r_t[48:24]};
                w_mul_b = {2'b00, w_adx};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_weight <= WEIGHT_RST;
            r_tol    <= TOL_RST;
            r_px     <= '0;
            r_py     <= '0;
            r_have   <= 1'b0;
            r_area   <= '0;
            r_mom    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WEIGHT: r_weight <= i_cfg_data;
                    CFG_TOL:    r_tol    <= i_cfg_data;
                    default:    r_tol    <= r_tol;
                endcase
            end
            case (r_state)
                S_XA:  r_area <= r_area + w_prod[AREA_W-1:0];
                S_SQ:  r_mom  <= r_mom + w_prod_ext;
                S_HW:  r_mom  <= r_mom + w_prod_ext;
                S_TRB: r_mom  <= r_mom + {16'd0, r_p[63:16]};
                S_FIN: begin
                    // the current corner becomes the previous one; the last one ends the curve
                    r_px   <= r_x1;
                    r_py   <= r_y1;
                    r_have <= !r_last;
                    if (r_last) begin
                        r_area <= '0;
                        r_mom  <= '0;
                    end
                end
                default: r_have <= r_have;
            endcase
            if ((r_state == S_RND) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x1   <= i_pt.point_x;
            r_y1   <= i_pt.point_y;
            r_last <= i_pt.last_point;
        end
        case (r_state)
            S_T2L: r_t <= w_prod[48:0];
            S_T2H: r_p <= {24'd0, w_prod[39:0]};
            // add the high partial product and the rounding half
            S_TRA: r_p <= r_p + {w_prod[39:0], 24'd0} + TRI_HALF;
            S_FIN: begin
                r_neg   <= r_area[AREA_W-1] ^ r_mom[MOM_W-1];
                r_empty <= (r_area == '0);
            end
            default: r_t <= r_t;
        endcase
        if ((r_state == S_RND) && w_out_free) begin
            r_cx     <= w_res;
            r_oempty <= r_empty;
        end
    end

    assign i_pt.ready       = w_ready;
    assign o_res.valid      = r_ovalid;
    assign o_res.centroid_x = r_cx;
    assign o_res.empty_area = r_oempty;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer idle after taking a request");

    a_seg_needs_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A2) |-> r_have)
        else $error("segment started without a previous corner");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_last) |=> ((r_area == '0) && (r_mom == '0) && !r_have))
        else $error("sums not cleared at end of curve");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RND) && w_out_free) |=> r_ovalid)
        else $error("result not presented");

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import plc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        t_x   cx;
        logic empty;
    } centroid_t;

    typedef struct {
        t_x        x;
        t_y        y;
        bit        last;
        bit        typed;
        centroid_t want;
    } corner_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [15:0] i_cfg_data;

    plc_in_if  pt_if ();
    plc_out_if res_if ();

    piecewise_linear_centroid_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    // predictor state and register copies
    longint    tri_weight = WEIGHT_RST;
    longint    flat_tol = TOL_RST;
    t_x        prev_x = '0;
    t_y        prev_y = '0;
    bit        have_prev = 0;
    bit [47:0] area_acc = '0;
    bit [63:0] moment_acc = '0;

    centroid_t expected_centroids[$];
    int        mismatches = 0;
    int        corners_sent = 0;
    int        src_idle_pct = 8;
    int        rcv_idle_pct = 69;
    bit        hold_req = 0;

    // one row per corner; a typed result only where it is obvious
    corner_row_t corner_rows [24] = '{
        '{16'sd0,      16'h8000, 1'b1, 1'b1, '{16'sd0, 1'b1}},  // lone corner
        '{16'sd0,      16'hFFFF, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd256,    16'hFFFF, 1'b1, 1'b1, '{16'sd128, 1'b0}}, // unit square
        '{-16'sd32768, 16'h0000, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd32767,  16'h0000, 1'b1, 1'b1, '{16'sd0, 1'b1}},  // zero height
        '{16'sd100,    16'd1000, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd100,    16'd2000, 1'b1, 1'b1, '{16'sd0, 1'b1}},  // zero width
        '{16'sd0,      16'hFFFF, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd512,    16'h0000, 1'b1, 1'b0, '{16'sd0, 1'b0}},  // falling
        '{-16'sd512,   16'h0000, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd0,      16'hFFFF, 1'b1, 1'b0, '{16'sd0, 1'b0}},  // rising
        '{16'sd256,    16'd1000, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd768,    16'd1007, 1'b0, 1'b0, '{16'sd0, 1'b0}},  // inside tolerance
        '{16'sd1024,   16'd1015, 1'b1, 1'b0, '{16'sd0, 1'b0}},  // just outside
        '{-16'sd32768, 16'hFFFF, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd32767,  16'hFFFF, 1'b1, 1'b0, '{16'sd0, 1'b0}},  // full span
        '{-16'sd32768, 16'd100,  1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd32767,  16'd100,  1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{-16'sd32767, 16'd100,  1'b1, 1'b0, '{16'sd0, 1'b0}},  // folds back, saturates
        '{16'sd1024,   16'd30000, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd0,      16'd30000, 1'b1, 1'b0, '{16'sd0, 1'b0}},  // negative area
        '{-16'sd256,   16'h0000, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd0,      16'hFFFF, 1'b0, 1'b0, '{16'sd0, 1'b0}},
        '{16'sd256,    16'h0000, 1'b1, 1'b0, '{16'sd0, 1'b0}}   // symmetric peak
    };

    function automatic bit take_corner(input t_x x, input t_y y, input bit last,
                                       output centroid_t res);
        longint    dx, a2, lx0, ly0, ly1;
        bit [63:0] adx, h, w, ylow, tri_part, m2, mmag, q, r;
        bit [47:0] amag;
        bit        aneg, mneg;
        res = '0;
        if (have_prev) begin
            lx0 = prev_x;
            ly0 = prev_y;
            ly1 = y;
            dx = longint'(x) - lx0;
            adx = (dx < 0) ? -dx : dx;
            h = 0;
            w = 0;
            ylow = ly0;
            if (ly0 > ly1 + flat_tol) begin
                h = ly0 - ly1;
                w = tri_weight;
                ylow = ly1;
                a2 = dx * (ly0 + ly1);
            end else if (ly0 + flat_tol < ly1) begin
                h = ly1 - ly0;
                w = 64'd65536 - tri_weight;
                a2 = dx * (ly0 + ly1);
            end else begin
                a2 = dx * 2 * ly0;
            end
            // the product may wrap at 64 bits before rounding, as in the block
            tri_part = (adx * h * w * adx + 64'd32768) >> 16;
            m2 = lx0 * a2 + adx * adx * ylow + tri_part;
            area_acc += a2[47:0];
            moment_acc += m2;
        end
        prev_x = x;
        prev_y = y;
        have_prev = 1;
        if (!last)
            return 0;
        aneg = area_acc[47];
        mneg = moment_acc[63];
        amag = aneg ? -area_acc : area_acc;
        mmag = mneg ? -moment_acc : moment_acc;
        if (amag == 0) begin
            res.empty = 1'b1;
        end else begin
            q = mmag / amag;
            r = mmag % amag;
            if (r >= amag - r)
                q++;
            if (aneg != mneg) begin
                if (q > 32768)
                    q = 32768;
                res.cx = 16'd0 - q[15:0];
            end else begin
                if (q > 32767)
                    q = 32767;
                res.cx = q[15:0];
            end
        end
        have_prev = 0;
        area_acc = '0;
        moment_acc = '0;
        return 1;
    endfunction

    task automatic send_point(input t_x x, input t_y y, input bit last,
                              input bit typed, input centroid_t want);
        centroid_t res;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pt_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid = 1'b1;
        pt_if.point_x = x;
        pt_if.point_y = y;
        pt_if.last_point = last;
        do
            @(posedge i_clk);
        while (pt_if.ready !== 1'b1);
        corners_sent++;
        if (take_corner(x, y, last, res))
            expected_centroids.push_back(typed ? want : res);
    endtask

    // drop the request, let every result out, then give the sequencer time to go idle
    task automatic drain_results();
        @(negedge i_clk);
        pt_if.valid = 1'b0;
        while (expected_centroids.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_WEIGHT)
            tri_weight = val;
        else
            flat_tol = val;
    endtask

    task automatic random_curve();
        int n, xi, yi, d, step;
        bit noisy;
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
        noisy = ($urandom_range(9) == 0);
        xi = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                      : int'($urandom_range(49152)) - 32768;
        yi = $urandom_range(65535);
        d = (flat_tol > 300) ? 300 : int'(flat_tol) + 2;
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                case ($urandom_range(3))
                    0: step = 0;
                    1: step = $urandom_range(1, 256);
                    2: step = $urandom_range(1, 4096);
                    default: step = $urandom_range(1, 32767);
                endcase
                if (noisy)
                    xi = int'($urandom_range(65535)) - 32768;
                else
                    xi = (xi + step > 32767) ? 32767 : xi + step;
                case ($urandom_range(4))
                    0, 1: yi = $urandom_range(65535);
                    2: yi = yi;
                    3: begin
                        yi = yi + int'($urandom_range(2 * d)) - d;
                        yi = (yi < 0) ? 0 : (yi > 65535) ? 65535 : yi;
                    end
                    default: yi = $urandom_range(1) ? 65535 : 0;
                endcase
            end
            send_point(xi[15:0], yi[15:0], i == n - 1, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        centroid_t want, got;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.cx = res_if.centroid_x;
                got.empty = res_if.empty_area;
                if (expected_centroids.size() == 0) begin
                    $display("%0t: unexpected result centroid_x %0d empty_area %0b",
                             $time, $signed(got.cx), got.empty);
                    mismatches++;
                end else begin
                    want = expected_centroids.pop_front();
                    if (got.cx !== want.cx) begin
                        $display("%0t: centroid_x expected %0d got %0d",
                                 $time, $signed(want.cx), $signed(got.cx));
                        mismatches++;
                    end
                    if (got.empty !== want.empty) begin
                        $display("%0t: empty_area expected %0b got %0b",
                                 $time, want.empty, got.empty);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((pt_if.valid === 1'b1 && pt_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] ph_weight [6];
        logic [15:0] ph_tol [6];
        int          ph_src [6];
        int          ph_rcv [6];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_WEIGHT;
        i_cfg_data = '0;
        pt_if.valid = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.last_point = 1'b0;

        ph_weight = '{WEIGHT_RST, 16'd0, 16'hFFFF, 16'($urandom), 16'h8000, 16'($urandom)};
        ph_tol = '{TOL_RST, 16'd0, 16'hFFFF, 16'($urandom_range(2000)), 16'd300,
                   16'($urandom_range(64))};
        ph_src = '{8, 8, 69, 69, 0, 0};
        ph_rcv = '{69, 69, 8, 8, 0, 0};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (corner_rows[i])
            send_point(corner_rows[i].x, corner_rows[i].y, corner_rows[i].last,
                       corner_rows[i].typed, corner_rows[i].want);

        for (int p = 0; p < 6; p++) begin
            drain_results();
            write_reg(CFG_WEIGHT, ph_weight[p]);
            write_reg(CFG_TOL, ph_tol[p]);
            src_idle_pct = ph_src[p];
            rcv_idle_pct = ph_rcv[p];
            // fill the block behind a stalled result port
            if (p == 4)
                hold_req = 1;
            while (corners_sent < 24 + (p + 1) * 238)
                random_curve();
        end

        drain_results();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
